// ----- rtl/core/mwem_pkg.sv -----
// Package for the Microwire EEPROM master: beat types, operation codes and defaults.
`default_nettype none
package mwem_pkg;

    localparam int CMD_BITS_DEF      = 11;
    localparam int INITIAL_SHIFT_DEF = 5;
    localparam logic [15:0] QUARTER_TICKS_RST = 16'd4;
    localparam logic [4:0]  DATA_BITS = 5'd8;

    typedef enum logic [2:0] {
        FUNC_NONE     = 3'd0,
        FUNC_SELECT   = 3'd1,
        FUNC_DESELECT = 3'd2,
        FUNC_FRAME    = 3'd3,
        FUNC_DATA     = 3'd4,
        FUNC_WAIT     = 3'd5
    } func_t;

    typedef enum logic [2:0] {
        OP_IDLE  = 3'd0,
        OP_DESEL = 3'd2,
        OP_FRAME = 3'd3,
        OP_DATA  = 3'd4,
        OP_WAIT  = 3'd5
    } op_t;

    // Quarters of one serial bit: SK low, high, high, low.
    typedef enum logic [1:0] {
        PH_LOW_A  = 2'd0,
        PH_HIGH_A = 2'd1,
        PH_HIGH_B = 2'd2,
        PH_LOW_B  = 2'd3
    } phase_t;

    typedef struct packed {
        logic [2:0]  func;
        logic [15:0] cmd_word;
        logic [15:0] cmd_address;
        logic        do_level;
    } mwem_in_t;

    typedef struct packed {
        logic       sk_out;
        logic       di_out;
        logic       cs_out;
        logic       busy_res;
        logic [7:0] read_byte;
        logic       op_done;
    } mwem_out_t;

endpackage
`default_nettype wire

// ----- rtl/core/mwem_step.sv -----
// Per-tick sequencer: bit timing state and the next-state/pin logic for one beat.
`default_nettype none
module mwem_step
    import mwem_pkg::*;
#(
    parameter int CMD_BITS      = CMD_BITS_DEF,
    parameter int INITIAL_SHIFT = INITIAL_SHIFT_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        step,
    input  wire mwem_in_t    in_beat,
    input  wire logic [15:0] quarter_ticks,
    output mwem_out_t        out_beat
);

    localparam logic [4:0] FRAME_BITS = 5'(CMD_BITS);

    op_t         op_reg,       op_next;
    phase_t      phase_reg,    phase_next;
    logic [15:0] tick_reg,     tick_next;
    logic [4:0]  bit_reg,      bit_next;
    logic [15:0] shout_reg,    shout_next;
    logic [7:0]  shin_reg,     shin_next;
    logic        sk_reg,       sk_next;
    logic        di_reg,       di_next;
    logic        cs_reg,       cs_next;

    logic        done;
    logic        start_bit;
    logic [15:0] q_len;
    logic [15:0] tick_inc;
    logic [4:0]  bit_inc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_reg    <= OP_IDLE;
            phase_reg <= PH_LOW_A;
            tick_reg  <= '0;
            bit_reg   <= '0;
            shout_reg <= '0;
            shin_reg  <= '0;
            sk_reg    <= 1'b0;
            di_reg    <= 1'b0;
            cs_reg    <= 1'b0;
        end else if (step) begin
            op_reg    <= op_next;
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            bit_reg   <= bit_next;
            shout_reg <= shout_next;
            shin_reg  <= shin_next;
            sk_reg    <= sk_next;
            di_reg    <= di_next;
            cs_reg    <= cs_next;
        end
    end

    always_comb begin
        op_next    = op_reg;
        phase_next = phase_reg;
        tick_next  = tick_reg;
        bit_next   = bit_reg;
        shout_next = shout_reg;
        shin_next  = shin_reg;
        sk_next    = sk_reg;
        di_next    = di_reg;
        cs_next    = cs_reg;
        done       = 1'b0;
        start_bit  = 1'b0;
        q_len      = (quarter_ticks == 16'd0) ? 16'd1 : quarter_ticks;
        tick_inc   = tick_reg + 16'd1;
        bit_inc    = bit_reg + 5'd1;

        if (op_reg != OP_IDLE) begin
            if (tick_inc < q_len) begin
                tick_next = tick_inc;
            end else begin
                tick_next = '0;
                case (phase_reg)
                    PH_LOW_A: begin
                        sk_next    = 1'b1;
                        phase_next = PH_HIGH_A;
                    end
                    PH_HIGH_A: begin
                        // DO sampled at the end of the first high quarter
                        if (op_reg == OP_DATA) begin
                            shin_next = {shin_reg[6:0], in_beat.do_level};
                        end else if (op_reg == OP_WAIT && in_beat.do_level) begin
                            bit_next = 5'd1;
                        end
                        phase_next = PH_HIGH_B;
                    end
                    PH_HIGH_B: begin
                        sk_next    = 1'b0;
                        phase_next = PH_LOW_B;
                    end
                    default: begin
                        phase_next = PH_LOW_A;
                        if (op_reg == OP_WAIT) begin
                            if (bit_reg != 5'd0) begin
                                bit_next = '0;
                                op_next  = OP_IDLE;
                                done     = 1'b1;
                            end else begin
                                start_bit = 1'b1;
                            end
                        end else if (op_reg == OP_DESEL) begin
                            op_next = OP_IDLE;
                            done    = 1'b1;
                        end else begin
                            shout_next = {shout_reg[14:0], 1'b0};
                            if (bit_inc >= ((op_reg == OP_FRAME) ? FRAME_BITS : DATA_BITS))
                            begin
                                bit_next = '0;
                                op_next  = OP_IDLE;
                                done     = 1'b1;
                            end else begin
                                bit_next  = bit_inc;
                                start_bit = 1'b1;
                            end
                        end
                    end
                endcase
            end
        end else begin
            case (in_beat.func)
                FUNC_SELECT: begin
                    cs_next = 1'b1;
                    done    = 1'b1;
                end
                FUNC_DESELECT: begin
                    cs_next   = 1'b0;
                    op_next   = OP_DESEL;
                    bit_next  = '0;
                    start_bit = 1'b1;
                end
                FUNC_FRAME: begin
                    op_next    = OP_FRAME;
                    shout_next = 16'((in_beat.cmd_word | in_beat.cmd_address)
                                     << INITIAL_SHIFT);
                    bit_next   = '0;
                    start_bit  = 1'b1;
                end
                FUNC_DATA: begin
                    op_next    = OP_DATA;
                    shout_next = {in_beat.cmd_word[7:0], 8'h00};
                    shin_next  = '0;
                    bit_next   = '0;
                    start_bit  = 1'b1;
                end
                FUNC_WAIT: begin
                    op_next   = OP_WAIT;
                    bit_next  = '0;
                    start_bit = 1'b1;
                end
                default: begin
                end
            endcase
        end

        // New bit: DI set up while SK is low, quarter timer restarts
        if (start_bit) begin
            if (op_next inside {OP_FRAME, OP_DATA}) begin
                di_next = shout_next[15];
            end else if (op_next == OP_WAIT) begin
                di_next = 1'b0;
            end
            sk_next    = 1'b0;
            phase_next = PH_LOW_A;
            tick_next  = '0;
        end
    end

    always_comb begin
        out_beat.sk_out    = sk_next;
        out_beat.di_out    = di_next;
        out_beat.cs_out    = cs_next;
        out_beat.busy_res  = (op_next != OP_IDLE);
        out_beat.read_byte = shin_next;
        out_beat.op_done   = done;
    end

endmodule
`default_nettype wire

// ----- rtl/core/microwire_eeprom_master_unit.sv -----
// Top level of the Microwire EEPROM master: input register, sequencer, result register.
`default_nettype none
// Each input beat is one tick of the pin-level Microwire master (93Cx6 EEPROMs) and
// produces exactly one result beat with the SK/DI/CS levels, busy, the byte read and
// a done strobe. One beat is taken per cycle while the result side is not stalled; a beat
// crosses the input register, the sequencer step and the result register, and its result is
// presented from the result register. The sequencer advances only when the result register
// is empty or being drained. quarter_ticks is to be written by the user through cfg_wr_en/cfg_wr_data
// only while the block is idle; the block itself does not enforce this. 0 behaves as 1.
module microwire_eeprom_master_unit
    import mwem_pkg::*;
#(
    parameter int CMD_BITS      = CMD_BITS_DEF,
    parameter int INITIAL_SHIFT = INITIAL_SHIFT_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire mwem_in_t    s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output mwem_out_t        m_data
);

    logic        in_valid_reg;
    mwem_in_t    in_data_reg;
    logic        out_valid_reg;
    mwem_out_t   out_data_reg;
    logic [15:0] quarter_ticks_reg;
    logic        step;
    mwem_out_t   step_beat;

    assign step    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || step;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quarter_ticks_reg <= QUARTER_TICKS_RST;
        end else if (cfg_wr_en) begin
            quarter_ticks_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (step) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (step) begin
            out_data_reg <= step_beat;
        end
    end

    mwem_step #(
        .CMD_BITS      (CMD_BITS),
        .INITIAL_SHIFT (INITIAL_SHIFT)
    ) u_step (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (step),
        .in_beat       (in_data_reg),
        .quarter_ticks (quarter_ticks_reg),
        .out_beat      (step_beat)
    );

`ifndef SYNTHESIS
    // a finishing command never reports busy on the same beat
    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.op_done && m_data.busy_res))
        else $error("op_done with busy_res set");

    a_accept_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> in_valid_reg)
        else $error("accepted beat not held in input register");

    a_step_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        step |=> (m_valid && m_data == $past(step_beat)))
        else $error("sequencer step did not produce a result beat");

    // a pending beat in the input stage is always drained once the output frees up
    a_no_stall_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !out_valid_reg) |-> step)
        else $error("input beat stalled with empty result register");
`endif

endmodule
`default_nettype wire

// ----- dv/tb.sv -----
// Testbench for the Microwire EEPROM master: pin-level scoreboard, stimulus and checks.
`default_nettype none
module tb;
    import mwem_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int LONG_HOLD   = 400;
    localparam logic [2:0] FUNC_RSVD6 = 3'd6;
    localparam logic [2:0] FUNC_RSVD7 = 3'd7;
    localparam int DO_LOW  = 0;
    localparam int DO_HIGH = 1;
    localparam int DO_RAND = 2;

    // Tracks the expected pin levels tick by tick and checks result beats in order.
    class pin_scoreboard;
        logic [15:0] quarter_len;
        op_t         op;
        phase_t      phase;
        logic [15:0] tick_cnt;
        logic [4:0]  bit_cnt;
        logic [15:0] tx_shift;
        logic [7:0]  rx_shift;
        logic        sk, di, cs;
        mwem_out_t   pins_expected[$];
        int          n_ticks;
        int          n_checked;
        int          n_errors;
        int          n_started[8];

        function new();
            quarter_len = QUARTER_TICKS_RST;
            op = OP_IDLE;
            phase = PH_LOW_A;
            tick_cnt = '0;
            bit_cnt = '0;
            tx_shift = '0;
            rx_shift = '0;
            sk = 1'b0;
            di = 1'b0;
            cs = 1'b0;
            n_ticks = 0;
            n_checked = 0;
            n_errors = 0;
            foreach (n_started[i]) n_started[i] = 0;
        endfunction

        function bit busy();
            return op != OP_IDLE;
        endfunction

        function int pending();
            return pins_expected.size();
        endfunction

        function void set_quarter(logic [15:0] v);
            quarter_len = v;
        endfunction

        function void start_bit();
            if (op == OP_FRAME || op == OP_DATA)
                di = tx_shift[15];
            else if (op == OP_WAIT)
                di = 1'b0;
            sk = 1'b0;
            phase = PH_LOW_A;
            tick_cnt = '0;
        endfunction

        // One tick of a running command; returns 1 when the command completes.
        function bit advance_tick(logic d);
            int qn;
            qn = (quarter_len == 16'd0) ? 1 : int'(quarter_len);
            tick_cnt = tick_cnt + 16'd1;
            if (int'(tick_cnt) < qn)
                return 1'b0;
            tick_cnt = '0;
            case (phase)
                PH_LOW_A: begin
                    sk = 1'b1;
                    phase = PH_HIGH_A;
                    return 1'b0;
                end
                PH_HIGH_A: begin
                    // DO sampled at the end of the first high quarter
                    if (op == OP_DATA)
                        rx_shift = {rx_shift[6:0], d};
                    else if (op == OP_WAIT && d)
                        bit_cnt = 5'd1;
                    phase = PH_HIGH_B;
                    return 1'b0;
                end
                PH_HIGH_B: begin
                    sk = 1'b0;
                    phase = PH_LOW_B;
                    return 1'b0;
                end
                default: ;
            endcase
            phase = PH_LOW_A;
            if (op == OP_WAIT) begin
                if (bit_cnt != 5'd0) begin
                    bit_cnt = '0;
                    op = OP_IDLE;
                    return 1'b1;
                end
                start_bit();
                return 1'b0;
            end
            if (op == OP_DESEL) begin
                op = OP_IDLE;
                return 1'b1;
            end
            bit_cnt = bit_cnt + 5'd1;
            tx_shift = tx_shift << 1;
            if (bit_cnt >= ((op == OP_FRAME) ? 5'(CMD_BITS_DEF) : DATA_BITS)) begin
                bit_cnt = '0;
                op = OP_IDLE;
                return 1'b1;
            end
            start_bit();
            return 1'b0;
        endfunction

        function void note_tick(mwem_in_t it);
            mwem_out_t r;
            logic      done;
            done = 1'b0;
            n_ticks++;
            if (op != OP_IDLE) begin
                done = advance_tick(it.do_level);
            end else begin
                n_started[it.func]++;
                case (it.func)
                    FUNC_SELECT: begin
                        cs = 1'b1;
                        done = 1'b1;
                    end
                    FUNC_DESELECT: begin
                        cs = 1'b0;
                        op = OP_DESEL;
                        bit_cnt = '0;
                        start_bit();
                    end
                    FUNC_FRAME: begin
                        op = OP_FRAME;
                        tx_shift = (it.cmd_word | it.cmd_address) << INITIAL_SHIFT_DEF;
                        bit_cnt = '0;
                        start_bit();
                    end
                    FUNC_DATA: begin
                        op = OP_DATA;
                        tx_shift = {it.cmd_word[7:0], 8'h00};
                        rx_shift = '0;
                        bit_cnt = '0;
                        start_bit();
                    end
                    FUNC_WAIT: begin
                        op = OP_WAIT;
                        bit_cnt = '0;
                        start_bit();
                    end
                    default: ;
                endcase
            end
            r.sk_out = sk;
            r.di_out = di;
            r.cs_out = cs;
            r.busy_res = (op != OP_IDLE);
            r.read_byte = rx_shift;
            r.op_done = done;
            pins_expected.push_back(r);
        endfunction

        function void compare_field(string name, logic [7:0] e, logic [7:0] g);
            if (g !== e) begin
                $error("%s: expected %0h, got %0h", name, e, g);
                n_errors++;
            end
        endfunction

        function void check_pins(mwem_out_t got);
            mwem_out_t e;
            if (pins_expected.size() == 0) begin
                $error("result beat with nothing expected: %p", got);
                n_errors++;
                return;
            end
            e = pins_expected.pop_front();
            n_checked++;
            compare_field("sk_out", 8'(e.sk_out), 8'(got.sk_out));
            compare_field("di_out", 8'(e.di_out), 8'(got.di_out));
            compare_field("cs_out", 8'(e.cs_out), 8'(got.cs_out));
            compare_field("busy_res", 8'(e.busy_res), 8'(got.busy_res));
            compare_field("read_byte", e.read_byte, got.read_byte);
            compare_field("op_done", 8'(e.op_done), 8'(got.op_done));
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;
    logic        s_valid;
    logic        s_ready;
    mwem_in_t    s_data;
    logic        m_valid;
    logic        m_ready;
    mwem_out_t   m_data;

    pin_scoreboard sb = new();
    mwem_in_t      cmd_plan[$];
    int            burst_left;
    int            stall_cycles;

    microwire_eeprom_master_unit #(
        .CMD_BITS      (CMD_BITS_DEF),
        .INITIAL_SHIFT (INITIAL_SHIFT_DEF)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            sb.note_tick(s_data);
        if (aresetn && m_valid && m_ready)
            sb.check_pins(m_data);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("watchdog: no beat moved for %0d cycles", STALL_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Receiver: random ready modes, plus two long hold-offs that back the block up.
    initial begin
        int mode;
        int mode_left;
        int holds;
        mode = 0;
        mode_left = 0;
        holds = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (holds < 2 && sb.n_ticks >= 900 + 400 * holds) begin
                holds++;
                m_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge aclk);
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 2);
                    mode_left = $urandom_range(30, 200);
                end
                mode_left--;
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= ($urandom_range(0, 9) < 7);
                    default: m_ready <= ($urandom_range(0, 9) < 3);
                endcase
            end
        end
    end

    function automatic mwem_in_t mk(logic [2:0] f, logic [15:0] w, logic [15:0] a, logic d);
        mwem_in_t it;
        it.func = f;
        it.cmd_word = w;
        it.cmd_address = a;
        it.do_level = d;
        return it;
    endfunction

    function automatic logic pick_do(int mode);
        if (mode == DO_LOW)
            return 1'b0;
        if (mode == DO_HIGH)
            return 1'b1;
        return 1'($urandom);
    endfunction

    // Tick while a command runs: with a noise_pct percent chance a command that must be ignored, else quiet.
    function automatic mwem_in_t busy_tick(int noise_pct);
        logic [2:0] f;
        logic       d;
        f = ($urandom_range(0, 99) < noise_pct) ? 3'($urandom_range(0, 7)) : FUNC_NONE;
        // keep ready polls going a few bits
        d = (sb.op == OP_WAIT) ? ($urandom_range(0, 7) == 0) : 1'($urandom);
        return mk(f, 16'($urandom), 16'($urandom), d);
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic offer(input mwem_in_t it);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic run_cmd(input logic [2:0] f, input logic [15:0] w, input logic [15:0] a,
                           input int do_mode);
        mwem_in_t it;
        offer(mk(f, w, a, pick_do(do_mode)));
        while (sb.busy()) begin
            it = busy_tick(100);
            it.do_level = pick_do(do_mode);
            offer(it);
        end
    endtask

    task automatic finish_command();
        while (sb.busy())
            offer(busy_tick(0));
    endtask

    // Only with no beat in flight: drain, let the pipeline settle, then write.
    task automatic write_quarter(input logic [15:0] v);
        s_valid <= 1'b0;
        while (sb.pending() > 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_quarter(v);
        @(negedge aclk);
    endtask

    function automatic void plan_transaction();
        int k;
        if ($urandom_range(0, 9) < 8) begin
            cmd_plan.push_back(mk(FUNC_SELECT, 16'($urandom), 16'($urandom), 1'($urandom)));
            if ($urandom_range(0, 3) == 0) begin
                cmd_plan.push_back(mk(FUNC_WAIT, 16'($urandom), 16'($urandom), 1'($urandom)));
            end else begin
                cmd_plan.push_back(mk(FUNC_FRAME, 16'($urandom), 16'($urandom),
                                      1'($urandom)));
                k = $urandom_range(0, 3);
                repeat (k)
                    cmd_plan.push_back(mk(FUNC_DATA, 16'($urandom), 16'($urandom),
                                          1'($urandom)));
            end
            cmd_plan.push_back(mk(FUNC_DESELECT, 16'($urandom), 16'($urandom), 1'($urandom)));
        end else begin
            // stray or out-of-sequence code
            cmd_plan.push_back(mk(3'($urandom_range(0, 7)), 16'($urandom), 16'($urandom),
                                  1'($urandom)));
        end
    endfunction

    task automatic random_phase(input int n_items);
        int stop_at;
        stop_at = sb.n_ticks + n_items;
        while (sb.n_ticks < stop_at) begin
            if (sb.busy()) begin
                offer(busy_tick(15));
            end else if ($urandom_range(0, 9) == 0) begin
                offer(mk(FUNC_NONE, 16'($urandom), 16'($urandom), 1'($urandom)));
            end else begin
                if (cmd_plan.size() == 0)
                    plan_transaction();
                offer(cmd_plan.pop_front());
            end
        end
        finish_command();
    endtask

    initial begin
        logic [2:0] f;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        burst_left = 0;
        stall_cycles = 0;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed, at the reset quarter length.
        run_cmd(FUNC_NONE, 16'hFFFF, 16'hFFFF, DO_HIGH);
        run_cmd(FUNC_FRAME, 16'hFFFF, 16'hFFFF, DO_RAND);   // frame with CS low
        run_cmd(FUNC_DATA, 16'hFFFF, 16'h0000, DO_HIGH);    // data with CS low
        run_cmd(FUNC_SELECT, 16'h0000, 16'h0000, DO_LOW);
        run_cmd(FUNC_SELECT, 16'hFFFF, 16'hFFFF, DO_HIGH);
        run_cmd(FUNC_FRAME, 16'h0000, 16'h0000, DO_LOW);
        run_cmd(FUNC_FRAME, 16'h0180, 16'h0023, DO_RAND);
        run_cmd(FUNC_DATA, 16'h0000, 16'hFFFF, DO_LOW);
        run_cmd(FUNC_DATA, 16'hFF5A, 16'h0000, DO_RAND);
        run_cmd(FUNC_WAIT, 16'h0000, 16'h0000, DO_HIGH);
        run_cmd(FUNC_WAIT, 16'hFFFF, 16'hFFFF, DO_RAND);
        run_cmd(FUNC_DESELECT, 16'h1234, 16'h4321, DO_RAND);
        run_cmd(FUNC_RSVD6, 16'hFFFF, 16'hFFFF, DO_HIGH);
        run_cmd(FUNC_RSVD7, 16'h0000, 16'h0000, DO_LOW);
        run_cmd(FUNC_DESELECT, 16'h0000, 16'h0000, DO_LOW);  // already deselected

        write_quarter(16'd1);
        random_phase(70);
        write_quarter(16'd0);                               // zero acts as one
        random_phase(70);
        write_quarter(16'd2);
        random_phase(70);
        write_quarter(16'd3);
        random_phase(50);
        // Longest quarter: only commands that finish at once.
        write_quarter(16'hFFFF);
        repeat (40) begin
            case ($urandom_range(0, 3))
                0: f = FUNC_SELECT;
                1: f = FUNC_RSVD6;
                2: f = FUNC_RSVD7;
                default: f = FUNC_NONE;
            endcase
            offer(mk(f, 16'($urandom), 16'($urandom), 1'($urandom)));
        end
        write_quarter(16'd1);
        random_phase(70);

        s_valid <= 1'b0;
        while (sb.pending() > 0) @(negedge aclk);
        repeat (8) @(posedge aclk);
        $display("covered %0d ticks, %0d result beats checked, quarter lengths 4 1 0 2 3 65535",
                 sb.n_ticks, sb.n_checked);
        $display("commands started: select %0d, deselect %0d, frame %0d, data %0d, wait %0d",
                 sb.n_started[FUNC_SELECT], sb.n_started[FUNC_DESELECT],
                 sb.n_started[FUNC_FRAME], sb.n_started[FUNC_DATA],
                 sb.n_started[FUNC_WAIT]);
        if (sb.n_errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
`default_nettype wire
